FILE: hdl/elx_pkg.sv
// Shared types, token codes and character constants for the expression lexer.
package elx_pkg;

  typedef enum logic [4:0] {
    TK_NUMBER  = 5'd0,
    TK_VAR     = 5'd1,
    TK_LPAREN  = 5'd2,
    TK_RPAREN  = 5'd3,
    TK_PLUS    = 5'd4,
    TK_MINUS   = 5'd5,
    TK_STAR    = 5'd6,
    TK_SLASH   = 5'd7,
    TK_PERCENT = 5'd8,
    TK_AND     = 5'd9,
    TK_OR      = 5'd10,
    TK_XOR     = 5'd11,
    TK_LT      = 5'd12,
    TK_GT      = 5'd13,
    TK_SHL     = 5'd14,
    TK_SHR     = 5'd15,
    TK_LE      = 5'd16,
    TK_GE      = 5'd17,
    TK_EQ      = 5'd18,
    TK_NE      = 5'd19,
    TK_BADCHAR = 5'd20,
    TK_BADSEQ  = 5'd21
  } tok_kind_t;

  typedef enum logic [2:0] {
    MODE_IDLE = 3'd0,
    MODE_NUM  = 3'd1,
    MODE_LT   = 3'd2,
    MODE_GT   = 3'd3,
    MODE_EQ   = 3'd4,
    MODE_NOT  = 3'd5,
    MODE_DROP = 3'd6
  } mode_t;

  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_NOT     = 8'h21;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_AMP     = 8'h26;
  localparam logic [7:0] CH_LPAREN  = 8'h28;
  localparam logic [7:0] CH_RPAREN  = 8'h29;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_LT      = 8'h3C;
  localparam logic [7:0] CH_EQ      = 8'h3D;
  localparam logic [7:0] CH_GT      = 8'h3E;
  localparam logic [7:0] CH_CARET   = 8'h5E;
  localparam logic [7:0] CH_T       = 8'h74;
  localparam logic [7:0] CH_BAR     = 8'h7C;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = 2;
  localparam int QUEUE_CNT_W = 3;

  typedef struct packed {
    tok_kind_t   kind;
    logic [31:0] value;
    logic        last;
  } token_t;

  // Results of one processed item, first then second.
  typedef struct packed {
    logic [1:0] count;
    token_t     first;
    token_t     second;
  } push_t;

  // TK_NUMBER means "not a single-character token".
  function automatic tok_kind_t single_kind(input logic [7:0] c);
    tok_kind_t k;
    case (c)
      CH_T:       k = TK_VAR;
      CH_LPAREN:  k = TK_LPAREN;
      CH_RPAREN:  k = TK_RPAREN;
      CH_PLUS:    k = TK_PLUS;
      CH_MINUS:   k = TK_MINUS;
      CH_STAR:    k = TK_STAR;
      CH_SLASH:   k = TK_SLASH;
      CH_PERCENT: k = TK_PERCENT;
      CH_AMP:     k = TK_AND;
      CH_BAR:     k = TK_OR;
      CH_CARET:   k = TK_XOR;
      default:    k = TK_NUMBER;
    endcase
    return k;
  endfunction

endpackage

FILE: hdl/elx_if.sv
// Valid/ready channel interfaces for characters in and tokens out.
interface elx_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_text;

  modport source(output valid, char_code, end_of_text, input ready);
  modport sink(input valid, char_code, end_of_text, output ready);
endinterface

interface elx_token_if;
  logic        valid;
  logic        ready;
  logic [4:0]  token_kind;
  logic [31:0] number_value;
  logic        run_last;

  modport source(output valid, token_kind, number_value, run_last, input ready);
  modport sink(input valid, token_kind, number_value, run_last, output ready);
endinterface

FILE: hdl/expression_char_lexer_unit.sv
// Top level of the expression character lexer.
// One character item enters per cycle through an input register while the queue has room;
// the step logic turns it into zero, one or two token items that go into a four-entry token
// queue. A stream whose characters give at most one token each runs at one character per
// cycle while the consumer is ready. A character that closes a number or a lone < or > and
// also starts a new token gives two tokens, which the queue hands out one at a time; the
// step waits whenever the queue has fewer than two free entries, so throughput is set by
// the queue's single output port. Tokens leave in order with run_last set on the last token
// of each character. After an error token, characters give nothing until the one marked
// end_of_text, which always returns the lexer to idle.
module expression_char_lexer_unit (
  input  logic        clk,
  input  logic        rst,
  elx_char_if.sink    char_in,
  elx_token_if.source token_out
);

  elx_pkg::push_t push;
  logic           room;

  elx_core u_core (
    .clk     (clk),
    .rst     (rst),
    .char_in (char_in),
    .room    (room),
    .push    (push)
  );

  elx_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .token_out (token_out)
  );

endmodule

FILE: hdl/elx_core.sv
// Input register, lexer state and the per-character step logic.
module elx_core (
  input  logic           clk,
  input  logic           rst,
  elx_char_if.sink       char_in,
  input  logic           room,
  output elx_pkg::push_t push
);

  logic               hold_valid;
  logic [7:0]         hold_char;
  logic               hold_eot;
  elx_pkg::mode_t     mode;
  elx_pkg::mode_t     mode_next;
  logic [31:0]        acc;
  logic [31:0]        acc_next;
  logic               advance;

  logic               digit;
  logic [3:0]         dval;
  logic [35:0]        acc_x10;
  logic [31:0]        acc_sat;
  elx_pkg::tok_kind_t sk;

  logic               fr_emit;
  elx_pkg::tok_kind_t fr_kind;
  logic [31:0]        fr_value;
  elx_pkg::mode_t     fr_mode;
  logic               fr_load;

  logic               emit0;
  elx_pkg::tok_kind_t kind0;
  logic [31:0]        val0;
  logic               emit1;
  elx_pkg::tok_kind_t kind1;
  logic [31:0]        val1;

  assign advance       = hold_valid && room;
  assign char_in.ready = !hold_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (char_in.ready) begin
      hold_valid <= char_in.valid;
    end
    if (char_in.ready && char_in.valid) begin
      hold_char <= char_in.char_code;
      hold_eot  <= char_in.end_of_text;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= elx_pkg::MODE_IDLE;
      acc  <= 32'd0;
    end else if (advance) begin
      mode <= mode_next;
      acc  <= acc_next;
    end
  end

  assign digit   = hold_char inside {[elx_pkg::CH_ZERO:elx_pkg::CH_NINE]};
  assign dval    = hold_char[3:0];
  assign acc_x10 = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {32'd0, dval};
  assign acc_sat = (acc_x10[35:32] != 4'd0) ? 32'hFFFF_FFFF : acc_x10[31:0];
  assign sk      = elx_pkg::single_kind(hold_char);

  // Lexing of the held character with nothing pending.
  always_comb begin
    fr_emit  = 1'b0;
    fr_kind  = elx_pkg::TK_NUMBER;
    fr_value = 32'd0;
    fr_mode  = elx_pkg::MODE_IDLE;
    fr_load  = 1'b0;
    if (hold_char == elx_pkg::CH_SPACE) begin
      fr_emit = 1'b0;
    end else if (sk != elx_pkg::TK_NUMBER) begin
      fr_emit = 1'b1;
      fr_kind = sk;
    end else if (hold_char == elx_pkg::CH_LT || hold_char == elx_pkg::CH_GT) begin
      if (hold_eot) begin
        fr_emit = 1'b1;
        fr_kind = (hold_char == elx_pkg::CH_LT) ? elx_pkg::TK_LT : elx_pkg::TK_GT;
      end else begin
        fr_mode = (hold_char == elx_pkg::CH_LT) ? elx_pkg::MODE_LT : elx_pkg::MODE_GT;
      end
    end else if (hold_char == elx_pkg::CH_EQ || hold_char == elx_pkg::CH_NOT) begin
      if (hold_eot) begin
        fr_emit = 1'b1;
        fr_kind = elx_pkg::TK_BADSEQ;
      end else begin
        fr_mode = (hold_char == elx_pkg::CH_EQ) ? elx_pkg::MODE_EQ : elx_pkg::MODE_NOT;
      end
    end else if (digit) begin
      fr_load = 1'b1;
      if (hold_eot) begin
        fr_emit  = 1'b1;
        fr_value = {28'd0, dval};
      end else begin
        fr_mode = elx_pkg::MODE_NUM;
      end
    end else begin
      fr_emit = 1'b1;
      fr_kind = elx_pkg::TK_BADCHAR;
      fr_mode = elx_pkg::MODE_DROP;
    end
  end

  // Next state.
  always_comb begin
    mode_next = fr_mode;
    acc_next  = fr_load ? {28'd0, dval} : acc;
    case (mode)
      elx_pkg::MODE_NUM: begin
        if (digit) begin
          mode_next = elx_pkg::MODE_NUM;
          acc_next  = acc_sat;
        end
      end
      elx_pkg::MODE_LT, elx_pkg::MODE_GT: begin
        if (hold_char == elx_pkg::CH_EQ ||
            (mode == elx_pkg::MODE_LT && hold_char == elx_pkg::CH_LT) ||
            (mode == elx_pkg::MODE_GT && hold_char == elx_pkg::CH_GT)) begin
          mode_next = elx_pkg::MODE_IDLE;
          acc_next  = acc;
        end
      end
      elx_pkg::MODE_EQ, elx_pkg::MODE_NOT: begin
        mode_next = (hold_char == elx_pkg::CH_EQ) ? elx_pkg::MODE_IDLE : elx_pkg::MODE_DROP;
        acc_next  = acc;
      end
      elx_pkg::MODE_DROP: begin
        mode_next = elx_pkg::MODE_DROP;
        acc_next  = acc;
      end
      default: begin
      end
    endcase
    if (hold_eot) begin
      mode_next = elx_pkg::MODE_IDLE;
      acc_next  = 32'd0;
    end
  end

  // Emitted tokens.
  always_comb begin
    emit0 = fr_emit;
    kind0 = fr_kind;
    val0  = fr_value;
    emit1 = 1'b0;
    kind1 = fr_kind;
    val1  = fr_value;
    case (mode)
      elx_pkg::MODE_NUM: begin
        if (digit) begin
          emit0 = hold_eot;
          kind0 = elx_pkg::TK_NUMBER;
          val0  = acc_sat;
        end else begin
          emit0 = 1'b1;
          kind0 = elx_pkg::TK_NUMBER;
          val0  = acc;
          emit1 = fr_emit;
        end
      end
      elx_pkg::MODE_LT, elx_pkg::MODE_GT: begin
        emit0 = 1'b1;
        val0  = 32'd0;
        if (mode == elx_pkg::MODE_LT && hold_char == elx_pkg::CH_LT) begin
          kind0 = elx_pkg::TK_SHL;
        end else if (mode == elx_pkg::MODE_GT && hold_char == elx_pkg::CH_GT) begin
          kind0 = elx_pkg::TK_SHR;
        end else if (hold_char == elx_pkg::CH_EQ) begin
          kind0 = (mode == elx_pkg::MODE_LT) ? elx_pkg::TK_LE : elx_pkg::TK_GE;
        end else begin
          kind0 = (mode == elx_pkg::MODE_LT) ? elx_pkg::TK_LT : elx_pkg::TK_GT;
          emit1 = fr_emit;
        end
      end
      elx_pkg::MODE_EQ, elx_pkg::MODE_NOT: begin
        emit0 = 1'b1;
        val0  = 32'd0;
        if (hold_char == elx_pkg::CH_EQ) begin
          kind0 = (mode == elx_pkg::MODE_EQ) ? elx_pkg::TK_EQ : elx_pkg::TK_NE;
        end else begin
          kind0 = elx_pkg::TK_BADSEQ;
        end
      end
      elx_pkg::MODE_DROP: begin
        emit0 = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    push.count        = advance ? ({1'b0, emit0} + {1'b0, emit1}) : 2'd0;
    push.first.kind   = kind0;
    push.first.value  = val0;
    push.first.last   = !emit1;
    push.second.kind  = kind1;
    push.second.value = val1;
    push.second.last  = 1'b1;
  end

  a_eot_idle: assert property (@(posedge clk) disable iff (rst)
    advance && hold_eot |=> mode == elx_pkg::MODE_IDLE && acc == 32'd0)
    else $error("lexer state not cleared after end of text");

  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(mode) && $stable(acc))
    else $error("lexer state changed without an item");

  a_drop_silent: assert property (@(posedge clk) disable iff (rst)
    advance && mode == elx_pkg::MODE_DROP |-> push.count == 2'd0)
    else $error("token emitted while dropping");

endmodule

FILE: hdl/elx_fifo.sv
// Token queue: takes up to two tokens per cycle, hands out one per cycle while the consumer is ready.
module elx_fifo (
  input  logic           clk,
  input  logic           rst,
  input  elx_pkg::push_t push,
  output logic           room,
  elx_token_if.source    token_out
);

  elx_pkg::token_t                  q [elx_pkg::QUEUE_DEPTH];
  logic [elx_pkg::QUEUE_PTR_W-1:0]  wp;
  logic [elx_pkg::QUEUE_PTR_W-1:0]  wp_inc;
  logic [elx_pkg::QUEUE_PTR_W-1:0]  rp;
  logic [elx_pkg::QUEUE_CNT_W-1:0]  count;
  logic                             pop;

  assign wp_inc = wp + elx_pkg::QUEUE_PTR_W'(1);
  assign pop    = token_out.valid && token_out.ready;
  assign room   = count <= elx_pkg::QUEUE_CNT_W'(elx_pkg::QUEUE_DEPTH - 2);

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      q[wp] <= push.first;
    end
    if (push.count == 2'd2) begin
      q[wp_inc] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      wp    <= wp + elx_pkg::QUEUE_PTR_W'(push.count);
      rp    <= rp + elx_pkg::QUEUE_PTR_W'(pop);
      count <= count + elx_pkg::QUEUE_CNT_W'(push.count) - elx_pkg::QUEUE_CNT_W'(pop);
    end
  end

  assign token_out.valid        = count != '0;
  assign token_out.token_kind   = q[rp].kind;
  assign token_out.number_value = q[rp].value;
  assign token_out.run_last     = q[rp].last;

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= elx_pkg::QUEUE_CNT_W'(elx_pkg::QUEUE_DEPTH))
    else $error("token queue overflow");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push.count != 2'd0 |-> room)
    else $error("tokens pushed without room");

endmodule
